// ===== rtl/vector_tile_geometry_decoder_unit_defines.svh =====
// assertion macros used by the top-level rtl file
`ifndef VECTOR_TILE_GEOMETRY_DECODER_UNIT_DEFINES_SVH
`define VECTOR_TILE_GEOMETRY_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define VTGD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vtgd assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define VTGD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vtgd assertion failed");
`else
`define VTGD_ASSERT_NOW(label, ante, cons)
`define VTGD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/vtgd_pkg.sv =====
package vtgd_pkg;

    // geometry kinds
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_POINT   = 2'd1;
    localparam logic [1:0] KIND_LINE    = 2'd2;
    localparam logic [1:0] KIND_POLYGON = 2'd3;

    // command ops
    localparam logic [2:0] OP_MOVE  = 3'd1;
    localparam logic [2:0] OP_LINE  = 3'd2;
    localparam logic [2:0] OP_CLOSE = 3'd7;
    localparam int         OP_SHIFT = 3;

    // word phases
    localparam logic [1:0] PH_CMD = 2'd0;
    localparam logic [1:0] PH_DX  = 2'd1;
    localparam logic [1:0] PH_DY  = 2'd2;

    // record kinds
    localparam logic [1:0] REC_VERTEX      = 2'd0;
    localparam logic [1:0] REC_PART_END    = 2'd1;
    localparam logic [1:0] REC_FEATURE_END = 2'd2;

    localparam logic [1:0] MAX_RECS = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] x;
        logic [31:0] y;
        logic        closing;
        logic [15:0] pts;
        logic        keep;
        logic [15:0] kept;
        logic        last;
    } rec_t;

    typedef struct packed {
        rec_t [2:0] recs;
        logic [1:0] cnt;
    } rec_buf_t;

    // zigzag decode
    function automatic logic [31:0] unzig(input logic [31:0] n);
        return (n >> 1) ^ {32{n[0]}};
    endfunction

    function automatic rec_t mk_rec(input logic [1:0] kind, input logic [31:0] x,
                                    input logic [31:0] y, input logic closing,
                                    input logic [15:0] pts, input logic keep,
                                    input logic [15:0] kept);
        rec_t r;
        r.kind    = kind;
        r.x       = x;
        r.y       = y;
        r.closing = closing;
        r.pts     = pts;
        r.keep    = keep;
        r.kept    = kept;
        r.last    = 1'b0;
        return r;
    endfunction

    // append a record to a step's result list
    function automatic rec_buf_t push(input rec_buf_t b, input rec_t r);
        rec_buf_t o;
        o = b;
        if (b.cnt != MAX_RECS)
        begin
            o.recs[b.cnt] = r;
            o.cnt         = b.cnt + 2'd1;
        end
        return o;
    endfunction

endpackage

// ===== rtl/vtgd_core.sv =====
module vtgd_core
    import vtgd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [31:0] word,
    input  logic [1:0]  geom_kind,
    input  logic        last_word,
    output rec_buf_t    step_recs
);

    localparam int CNT_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
    localparam logic [CNT_W-1:0] CNT_CAP = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_CAP) ? CNT_CAP : v + CNT_ONE;
    endfunction

    logic [31:0]      cursor_x_reg, cursor_x_next;
    logic [31:0]      cursor_y_reg, cursor_y_next;
    logic [1:0]       phase_reg, phase_next;
    logic [28:0]      pairs_left_reg, pairs_left_next;
    logic [31:0]      pending_dx_reg, pending_dx_next;
    logic [CNT_W-1:0] part_count_reg, part_count_next;
    logic [31:0]      first_x_reg, first_x_next;
    logic [31:0]      first_y_reg, first_y_next;
    logic             stopped_reg, stopped_next;
    logic [CNT_W-1:0] kept_count_reg, kept_count_next;

    logic [2:0]  op;
    logic [28:0] cmd_count;
    logic        end_keep;

    assign op        = word[OP_SHIFT-1:0];
    assign cmd_count = word[31:OP_SHIFT];

    // one word through the decoder, in the order the records come out
    always_comb
    begin
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        phase_next      = phase_reg;
        pairs_left_next = pairs_left_reg;
        pending_dx_next = pending_dx_reg;
        part_count_next = part_count_reg;
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        stopped_next    = stopped_reg;
        kept_count_next = kept_count_reg;
        step_recs       = '0;
        end_keep        = 1'b0;

        if (geom_kind != KIND_NONE && !stopped_reg)
        begin
            // dangling dx on the last word is taken as a command
            if (phase_next == PH_DX && last_word)
                phase_next = PH_CMD;
            case (phase_next)
                PH_DX:
                begin
                    pending_dx_next = unzig(word);
                    phase_next      = PH_DY;
                end
                PH_DY:
                begin
                    cursor_x_next = cursor_x_reg + pending_dx_reg;
                    cursor_y_next = cursor_y_reg + unzig(word);
                    if (geom_kind == KIND_POINT)
                    begin
                        step_recs = push(step_recs, mk_rec(REC_VERTEX, cursor_x_next,
                                         cursor_y_next, 1'b0, 16'd0, 1'b0, 16'd0));
                        step_recs = push(step_recs, mk_rec(REC_PART_END, 32'd0, 32'd0,
                                         1'b0, 16'(sat_inc(part_count_reg)), 1'b1, 16'd0));
                        kept_count_next = sat_inc(kept_count_reg);
                        part_count_next = '0;
                    end
                    else
                    begin
                        if (geom_kind == KIND_POLYGON && part_count_reg == '0)
                        begin
                            first_x_next = cursor_x_next;
                            first_y_next = cursor_y_next;
                        end
                        part_count_next = sat_inc(part_count_reg);
                        step_recs = push(step_recs, mk_rec(REC_VERTEX, cursor_x_next,
                                         cursor_y_next, 1'b0, 16'd0, 1'b0, 16'd0));
                    end
                    pairs_left_next = pairs_left_reg - 29'd1;
                    phase_next      = (pairs_left_next != '0) ? PH_DX : PH_CMD;
                end
                default:
                begin
                    phase_next = PH_CMD;
                    case (geom_kind)
                        KIND_POINT:
                        begin
                            if (op != OP_MOVE)
                                stopped_next = 1'b1;
                            else if (cmd_count != '0)
                            begin
                                pairs_left_next = cmd_count;
                                phase_next      = PH_DX;
                            end
                        end
                        KIND_LINE:
                        begin
                            if (op == OP_MOVE)
                            begin
                                // finish the current line
                                end_keep = (part_count_reg >= CNT_TWO);
                                if (part_count_reg != '0)
                                begin
                                    step_recs = push(step_recs, mk_rec(REC_PART_END, 32'd0,
                                                     32'd0, 1'b0, 16'(part_count_reg),
                                                     end_keep, 16'd0));
                                    if (end_keep)
                                        kept_count_next = sat_inc(kept_count_reg);
                                end
                                part_count_next = '0;
                                if (cmd_count != '0)
                                begin
                                    pairs_left_next = 29'd1;
                                    phase_next      = PH_DX;
                                end
                            end
                            else if (op == OP_LINE)
                            begin
                                if (cmd_count != '0)
                                begin
                                    pairs_left_next = cmd_count;
                                    phase_next      = PH_DX;
                                end
                            end
                            else
                                stopped_next = 1'b1;
                        end
                        default:
                        begin
                            if (op == OP_MOVE)
                            begin
                                // abandon the open ring
                                if (part_count_reg != '0)
                                    step_recs = push(step_recs, mk_rec(REC_PART_END, 32'd0,
                                                     32'd0, 1'b0, 16'(part_count_reg),
                                                     1'b0, 16'd0));
                                part_count_next = '0;
                                if (cmd_count != '0)
                                begin
                                    pairs_left_next = 29'd1;
                                    phase_next      = PH_DX;
                                end
                            end
                            else if (op == OP_LINE)
                            begin
                                if (cmd_count != '0)
                                begin
                                    pairs_left_next = cmd_count;
                                    phase_next      = PH_DX;
                                end
                            end
                            else if (op == OP_CLOSE && part_count_reg >= CNT_THREE)
                            begin
                                // closing vertex then a kept ring
                                step_recs = push(step_recs, mk_rec(REC_VERTEX, first_x_reg,
                                                 first_y_reg, 1'b1, 16'd0, 1'b0, 16'd0));
                                step_recs = push(step_recs, mk_rec(REC_PART_END, 32'd0,
                                                 32'd0, 1'b0, 16'(sat_inc(part_count_reg)),
                                                 1'b1, 16'd0));
                                kept_count_next = sat_inc(kept_count_reg);
                                part_count_next = '0;
                            end
                        end
                    endcase
                end
            endcase
        end

        // feature end: flush the open part, report, clear state
        if (last_word)
        begin
            if (part_count_next != '0)
            begin
                end_keep  = (geom_kind == KIND_LINE) && (part_count_next >= CNT_TWO);
                step_recs = push(step_recs, mk_rec(REC_PART_END, 32'd0, 32'd0, 1'b0,
                                 16'(part_count_next), end_keep, 16'd0));
                if (end_keep)
                    kept_count_next = sat_inc(kept_count_next);
            end
            step_recs = push(step_recs, mk_rec(REC_FEATURE_END, 32'd0, 32'd0, 1'b0,
                             16'd0, 1'b0, 16'(kept_count_next)));
            cursor_x_next   = '0;
            cursor_y_next   = '0;
            phase_next      = PH_CMD;
            pairs_left_next = '0;
            pending_dx_next = '0;
            part_count_next = '0;
            first_x_next    = '0;
            first_y_next    = '0;
            stopped_next    = 1'b0;
            kept_count_next = '0;
        end

        // mark the last record of this word
        if (step_recs.cnt != 2'd0)
            step_recs.recs[step_recs.cnt - 2'd1].last = 1'b1;
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            phase_reg      <= PH_CMD;
            pairs_left_reg <= '0;
            pending_dx_reg <= '0;
            part_count_reg <= '0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            stopped_reg    <= 1'b0;
            kept_count_reg <= '0;
        end
        else if (step)
        begin
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            phase_reg      <= phase_next;
            pairs_left_reg <= pairs_left_next;
            pending_dx_reg <= pending_dx_next;
            part_count_reg <= part_count_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            stopped_reg    <= stopped_next;
            kept_count_reg <= kept_count_next;
        end
    end

endmodule

// ===== rtl/vtgd_outbuf.sv =====
module vtgd_outbuf
    import vtgd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  rec_buf_t load_recs,
    output logic     can_load,
    output logic     rec_valid,
    input  logic     rec_ready,
    output rec_t     rec
);

    rec_buf_t   recs_reg;
    logic [1:0] pos_reg, pos_next;
    logic [1:0] rem_reg, rem_next;
    logic       take;

    assign rec_valid = (rem_reg != 2'd0);
    assign take      = rec_valid && rec_ready;
    assign can_load  = (rem_reg == 2'd0) || (rem_reg == 2'd1 && rec_ready);
    assign rec       = recs_reg.recs[pos_reg];

    // walk through the held records, reload once the last one goes
    always_comb
    begin
        pos_next = pos_reg;
        rem_next = rem_reg;
        if (take)
        begin
            pos_next = pos_reg + 2'd1;
            rem_next = rem_reg - 2'd1;
        end
        if (load)
        begin
            pos_next = 2'd0;
            rem_next = load_recs.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            rem_reg <= 2'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            rem_reg <= rem_next;
        end
    end

    // record payload
    always_ff @(posedge clk)
    begin
        if (load)
            recs_reg <= load_recs;
    end

endmodule

// ===== rtl/vector_tile_geometry_decoder_unit.sv =====
// Vector tile geometry decoder.
// Slave channel: one 32-bit geometry word per transaction on s_tdata, the
// geometry kind (1 point, 2 linestring, 3 polygon, 0 ignored) on s_tuser and
// the final word of a feature on s_tlast.
// Master channel: one record per transaction; m_tuser gives the record kind
// (0 vertex, 1 end of part, 2 end of feature), m_tdata the record fields and
// m_tlast marks the last record caused by one input word.
// A word is held in an input register, decoded combinationally against the
// cursor and part state, and its zero to three records land in a small
// output buffer, a second register that drives m_tvalid. Throughput is one
// word per cycle while each word gives at most one record and m_tready stays
// high; a word with more records holds the output buffer until all have gone,
// so the output buffer sets the rate. Words that make no record pass at one
// per cycle while the output buffer can load.
// When the receiver stalls, the output buffer and input register fill and
// s_tready drops; nothing is lost. Reset clears the cursor, counts and
// phase and empties both registers; decoder state also clears after every
// word marked last.
`include "vector_tile_geometry_decoder_unit_defines.svh"

module vector_tile_geometry_decoder_unit
    import vtgd_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // word
    input  logic [1:0]   s_tuser,   // geom_kind
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // x_coord, y_coord, is_closing, part_points, keep, kept_parts
    output logic [1:0]   m_tuser,   // record_kind
    output logic         m_tlast
);

    logic        in_valid_reg;
    logic [31:0] word_reg;
    logic [1:0]  kind_reg;
    logic        last_reg;
    logic        can_load;
    logic        fire;
    rec_buf_t    step_recs;
    rec_t        rec;

    assign fire     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || fire;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            word_reg <= s_tdata;
            kind_reg <= s_tuser;
            last_reg <= s_tlast;
        end
    end

    // decode one word
    vtgd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (fire),
        .word      (word_reg),
        .geom_kind (kind_reg),
        .last_word (last_reg),
        .step_recs (step_recs)
    );

    // hand records out one per transaction
    vtgd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .load_recs (step_recs),
        .can_load  (can_load),
        .rec_valid (m_tvalid),
        .rec_ready (m_tready),
        .rec       (rec)
    );

    // output packing
    assign m_tdata = {6'd0, rec.kept, rec.keep, rec.pts, rec.closing, rec.y, rec.x};
    assign m_tuser = rec.kind;
    assign m_tlast = rec.last;

    // checks
    `VTGD_ASSERT_NEXT(a_in_held, s_tvalid && s_tready, in_valid_reg)
    `VTGD_ASSERT_NOW(a_feature_end_last, m_tvalid && m_tuser == REC_FEATURE_END, m_tlast)
    `VTGD_ASSERT_NOW(a_closing_on_vertex, m_tvalid && m_tuser != REC_VERTEX, !m_tdata[64])
    `VTGD_ASSERT_NOW(a_kind_known, m_tvalid,
        m_tuser == REC_VERTEX || m_tuser == REC_PART_END || m_tuser == REC_FEATURE_END)

endmodule
